// ===== hdl/ppc_pkg.sv =====
package ppc_pkg;

   localparam int POS_W      = 12;
   localparam int SP_W       = 8;
   localparam int GAIN_W     = 16;
   localparam int DZ_W       = 4;
   localparam int LIM_W      = 7;
   localparam int OUT_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ERR_W      = 13;
   localparam int LAST_W     = 14;
   localparam int INTEG_W    = 18;
   localparam int MUL_A_W    = 17;
   localparam int MUL_B_W    = 18;
   localparam int PROD_W     = 35;
   localparam int SUM_W      = 32;
   localparam int CLAMP_W    = 24;
   localparam int FRAC_W     = 16;

   typedef logic [POS_W-1:0]      position_type;
   typedef logic [SP_W-1:0]       setpoint_type;
   typedef logic [GAIN_W-1:0]     gain_type;
   typedef logic [DZ_W-1:0]       deadzone_type;
   typedef logic [LIM_W-1:0]      limit_type;
   typedef logic signed [OUT_W-1:0] pulse_type;
   typedef logic [CSR_IDX_W-1:0]  csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT = 3'd0,
      CSR_KP       = 3'd1,
      CSR_KI_DT    = 3'd2,
      CSR_KD_DT    = 3'd3,
      CSR_DEADZONE = 3'd4,
      CSR_WINDUP   = 3'd5,
      CSR_UPPER    = 3'd6,
      CSR_LOWER    = 3'd7
   } csr_index_type;

   localparam setpoint_type SETPOINT_LO  = 8'd30;
   localparam setpoint_type SETPOINT_HI  = 8'd130;
   localparam setpoint_type SETPOINT_RST = 8'd100;
   localparam gain_type     KP_RST       = 16'd3840;
   localparam gain_type     KI_DT_RST    = 16'd0;
   localparam gain_type     KD_DT_RST    = 16'd0;
   localparam deadzone_type DEADZONE_RST = 4'd2;
   localparam gain_type     WINDUP_RST   = 16'd38400;
   localparam limit_type    UPPER_RST    = 7'd40;
   localparam limit_type    LOWER_RST    = 7'd30;

   localparam logic signed [MUL_A_W-1:0] GRAVITY_NUM = 17'sd179;
   localparam logic signed [MUL_A_W-1:0] UNITY_NUM   = 17'sd256;

   localparam logic signed [MUL_B_W-1:0] PRESCALE_MAX = 18'sd65535;
   localparam logic signed [MUL_B_W-1:0] PRESCALE_MIN = -18'sd65536;

endpackage

// ===== hdl/pid_position_controller_core.sv =====
// Channel   Direction  Ports                                   Handshake
// req       in         req_position_mm                         req_valid / req_ready
// rsp       out        rsp_pulse_adjust_us, rsp_saturated      rsp_valid / rsp_ready
// csr       in         csr_index, csr_wdata                    csr_we
//
// A transaction is accepted only in the idle step and passes through the P, I, D, WIND,
// SUM, SCALE and OUT steps to the result register on the single shared 17x18 multiplier,
// so no request is taken until idle. Reset is synchronous; it restores the configuration
// registers to their documented values and clears the integrator and last error.
// A waiting response does not block the next request, but the sequencer holds in its
// final step until the response register is free.
module pid_position_controller_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ppc_pkg::position_type    req_position_mm,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ppc_pkg::pulse_type       rsp_pulse_adjust_us,
   output logic                     rsp_saturated,
   input  logic                     csr_we,
   input  ppc_pkg::csr_addr_type    csr_index,
   input  ppc_pkg::csr_data_type    csr_wdata
);
   import ppc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_P     = 8'b0000_0010,
      ST_I     = 8'b0000_0100,
      ST_D     = 8'b0000_1000,
      ST_WIND  = 8'b0001_0000,
      ST_SUM   = 8'b0010_0000,
      ST_SCALE = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   setpoint_type setpoint_ff, setpoint_in;
   gain_type     kp_ff, kp_in;
   gain_type     ki_ff, ki_in;
   gain_type     kd_ff, kd_in;
   deadzone_type deadzone_ff, deadzone_in;
   gain_type     windup_ff, windup_in;
   limit_type    upper_ff, upper_in;
   limit_type    lower_ff, lower_in;

   logic signed [INTEG_W-1:0] integral_ff, integral_in;
   logic signed [LAST_W-1:0]  last_error_ff, last_error_in;
   logic signed [ERR_W-1:0]   eff_ff, eff_in;
   logic signed [LAST_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SUM_W-1:0]   integ_ff, integ_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   pulse_type                 pulse_ff, pulse_in;
   logic                      sat_ff, sat_in;

   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W-1:0]   err_mag;
   logic signed [LAST_W-1:0]  err_ext;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [MUL_B_W-1:0] sum_pre;
   logic signed [SUM_W-1:0]   prod_low;
   logic signed [SUM_W-1:0]   wl_pos;
   logic signed [SUM_W-1:0]   wl_neg;
   logic signed [PROD_W-1:0]  out_hi;
   logic signed [PROD_W-1:0]  out_lo;
   logic signed [PROD_W-1:0]  clamped;
   logic signed [CLAMP_W-1:0] clamped_nar;
   logic signed [CLAMP_W-1:0] clamped_mag;
   logic                      out_free;
   logic                      accept;

   assign req_ready           = (state_ff == ST_IDLE);
   assign accept              = req_valid && req_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pulse_adjust_us = pulse_ff;
   assign rsp_saturated       = sat_ff;
   assign out_free            = !rsp_valid_ff || rsp_ready;

   assign err     = $signed({{(ERR_W-SP_W){1'b0}}, setpoint_ff})
                  - $signed({{(ERR_W-POS_W){1'b0}}, req_position_mm});
   assign err_mag = err[ERR_W-1] ? -err : err;
   assign err_ext = {err[ERR_W-1], err};

   assign prod_low = prod_ff[SUM_W-1:0];
   assign wl_pos   = $signed({{(SUM_W-GAIN_W){1'b0}}, windup_ff});
   assign wl_neg   = -wl_pos;
   assign out_hi   = $signed({{(PROD_W-LIM_W-FRAC_W){1'b0}}, upper_ff, {FRAC_W{1'b0}}});
   assign out_lo   = -$signed({{(PROD_W-LIM_W-FRAC_W){1'b0}}, lower_ff, {FRAC_W{1'b0}}});

   always_comb begin
      if (sum_ff > SUM_W'(PRESCALE_MAX)) begin
         sum_pre = PRESCALE_MAX;
      end else if (sum_ff < SUM_W'(PRESCALE_MIN)) begin
         sum_pre = PRESCALE_MIN;
      end else begin
         sum_pre = sum_ff[MUL_B_W-1:0];
      end
   end

   always_comb begin
      case (state_ff)
         ST_P: begin
            mul_a = $signed({1'b0, kp_ff});
            mul_b = MUL_B_W'(eff_ff);
         end
         ST_I: begin
            mul_a = $signed({1'b0, ki_ff});
            mul_b = MUL_B_W'(eff_ff);
         end
         ST_D: begin
            mul_a = $signed({1'b0, kd_ff});
            mul_b = MUL_B_W'(diff_ff);
         end
         ST_SCALE: begin
            mul_a = sum_ff[SUM_W-1] ? GRAVITY_NUM : UNITY_NUM;
            mul_b = sum_pre;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      if (prod_ff > out_hi) begin
         clamped = out_hi;
      end else if (prod_ff < out_lo) begin
         clamped = out_lo;
      end else begin
         clamped = prod_ff;
      end
   end

   assign clamped_nar = clamped[CLAMP_W-1:0];
   assign clamped_mag = -clamped_nar;

   always_comb begin
      setpoint_in   = setpoint_ff;
      kp_in         = kp_ff;
      ki_in         = ki_ff;
      kd_in         = kd_ff;
      deadzone_in   = deadzone_ff;
      windup_in     = windup_ff;
      upper_in      = upper_ff;
      lower_in      = lower_ff;
      state_in      = state_ff;
      integral_in   = integral_ff;
      last_error_in = last_error_ff;
      eff_in        = eff_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      integ_in      = integ_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pulse_in      = pulse_ff;
      sat_in        = sat_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_SETPOINT: begin
               if (csr_wdata[SP_W-1:0] < SETPOINT_LO) begin
                  setpoint_in = SETPOINT_LO;
               end else if (csr_wdata[SP_W-1:0] > SETPOINT_HI) begin
                  setpoint_in = SETPOINT_HI;
               end else begin
                  setpoint_in = csr_wdata[SP_W-1:0];
               end
            end
            CSR_KP:       kp_in       = csr_wdata[GAIN_W-1:0];
            CSR_KI_DT:    ki_in       = csr_wdata[GAIN_W-1:0];
            CSR_KD_DT:    kd_in       = csr_wdata[GAIN_W-1:0];
            CSR_DEADZONE: deadzone_in = csr_wdata[DZ_W-1:0];
            CSR_WINDUP:   windup_in   = csr_wdata[GAIN_W-1:0];
            CSR_UPPER:    upper_in    = csr_wdata[LIM_W-1:0];
            CSR_LOWER:    lower_in    = csr_wdata[LIM_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (err_mag < $signed({{(ERR_W-DZ_W){1'b0}}, deadzone_ff})) begin
                  eff_in = '0;
               end else begin
                  eff_in = err;
               end
               diff_in       = err_ext - last_error_ff;
               last_error_in = err_ext;
               state_in      = ST_P;
            end
         end
         ST_P: begin
            prod_in  = mul_p;
            state_in = ST_I;
         end
         ST_I: begin
            prod_in  = mul_p;
            sum_in   = prod_low;
            state_in = ST_D;
         end
         ST_D: begin
            prod_in  = mul_p;
            integ_in = SUM_W'(integral_ff) + prod_low;
            state_in = ST_WIND;
         end
         ST_WIND: begin
            sum_in = sum_ff + prod_low;
            if (integ_ff > wl_pos) begin
               integral_in = wl_pos[INTEG_W-1:0];
            end else if (integ_ff < wl_neg) begin
               integral_in = wl_neg[INTEG_W-1:0];
            end else begin
               integral_in = integ_ff[INTEG_W-1:0];
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in   = sum_ff + SUM_W'(integral_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = mul_p;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               sat_in       = (prod_ff > out_hi) || (prod_ff < out_lo);
               if (clamped_nar[CLAMP_W-1]) begin
                  pulse_in = clamped_mag[CLAMP_W-1:FRAC_W];
               end else begin
                  pulse_in = -$signed(clamped_nar[CLAMP_W-1:FRAC_W]);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         setpoint_ff   <= SETPOINT_RST;
         kp_ff         <= KP_RST;
         ki_ff         <= KI_DT_RST;
         kd_ff         <= KD_DT_RST;
         deadzone_ff   <= DEADZONE_RST;
         windup_ff     <= WINDUP_RST;
         upper_ff      <= UPPER_RST;
         lower_ff      <= LOWER_RST;
         integral_ff   <= '0;
         last_error_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         setpoint_ff   <= setpoint_in;
         kp_ff         <= kp_in;
         ki_ff         <= ki_in;
         kd_ff         <= kd_in;
         deadzone_ff   <= deadzone_in;
         windup_ff     <= windup_in;
         upper_ff      <= upper_in;
         lower_ff      <= lower_in;
         integral_ff   <= integral_in;
         last_error_ff <= last_error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eff_ff   <= eff_in;
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      integ_ff <= integ_in;
      pulse_ff <= pulse_in;
      sat_ff   <= sat_in;
   end

endmodule

// ===== tb/sv/tb_pid_position_controller_core.sv =====
module tb_pid_position_controller_core;
   import ppc_pkg::*;

   typedef struct packed {
      pulse_type pulse;
      logic      sat;
   } pulse_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   position_type req_position_mm = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   pulse_type    rsp_pulse_adjust_us;
   logic         rsp_saturated;
   logic         csr_we = 1'b0;
   csr_addr_type csr_index = '0;
   csr_data_type csr_wdata = '0;

   setpoint_type cfg_setpoint;
   gain_type     cfg_kp;
   gain_type     cfg_ki;
   gain_type     cfg_kd;
   gain_type     cfg_windup;
   deadzone_type cfg_deadzone;
   limit_type    cfg_upper;
   limit_type    cfg_lower;
   longint       integral_state;
   longint       last_error_state;

   pulse_result_type pulse_queue[$];
   int error_count = 0;
   int sample_count = 0;
   int response_count = 0;
   int write_count = 0;
   int saturated_count = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_cycles = 0;
   int rsp_stall_left = 0;

   pid_position_controller_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_position_mm     (req_position_mm),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pulse_adjust_us (rsp_pulse_adjust_us),
      .rsp_saturated       (rsp_saturated),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(8, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic void reset_controller_model();
      cfg_setpoint     = SETPOINT_RST;
      cfg_kp           = KP_RST;
      cfg_ki           = KI_DT_RST;
      cfg_kd           = KD_DT_RST;
      cfg_deadzone     = DEADZONE_RST;
      cfg_windup       = WINDUP_RST;
      cfg_upper        = UPPER_RST;
      cfg_lower        = LOWER_RST;
      integral_state   = 0;
      last_error_state = 0;
   endfunction

   function automatic pulse_result_type compute_pulse_adjust(position_type pos);
      longint err, mag, eff, p_term, integ, d_term, sum, v16, hi, lo, wl;
      pulse_result_type r;
      err = longint'(cfg_setpoint) - longint'(pos);
      mag = (err < 0) ? -err : err;
      eff = (mag < longint'(cfg_deadzone)) ? 0 : err;
      p_term = longint'(cfg_kp) * eff;
      integ = integral_state + longint'(cfg_ki) * eff;
      wl = longint'(cfg_windup);
      if (integ > wl) begin
         integ = wl;
      end
      if (integ < -wl) begin
         integ = -wl;
      end
      integral_state = integ;
      d_term = longint'(cfg_kd) * (err - last_error_state);
      last_error_state = err;
      sum = p_term + integ + d_term;
      v16 = (sum < 0) ? sum * 179 : sum * 256;
      hi = longint'(cfg_upper) * 65536;
      lo = -longint'(cfg_lower) * 65536;
      r.sat = 1'b0;
      if (v16 > hi) begin
         v16 = hi;
         r.sat = 1'b1;
      end
      if (v16 < lo) begin
         v16 = lo;
         r.sat = 1'b1;
      end
      r.pulse = pulse_type'((-v16) / 65536);
      return r;
   endfunction

   task automatic send_position(input position_type pos);
      int gap;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_position_mm <= pos;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pulse_queue.push_back(compute_pulse_adjust(pos));
      sample_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pulse_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input csr_index_type idx, input csr_data_type data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SETPOINT: begin
            if (data[7:0] < SETPOINT_LO) begin
               cfg_setpoint = SETPOINT_LO;
            end else if (data[7:0] > SETPOINT_HI) begin
               cfg_setpoint = SETPOINT_HI;
            end else begin
               cfg_setpoint = data[7:0];
            end
         end
         CSR_KP:       cfg_kp = data;
         CSR_KI_DT:    cfg_ki = data;
         CSR_KD_DT:    cfg_kd = data;
         CSR_DEADZONE: cfg_deadzone = data[3:0];
         CSR_WINDUP:   cfg_windup = data;
         CSR_UPPER:    cfg_upper = data[6:0];
         CSR_LOWER:    cfg_lower = data[6:0];
         default: begin
         end
      endcase
      write_count++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_gains(input csr_data_type setpoint, input csr_data_type kp,
                                input csr_data_type ki, input csr_data_type kd,
                                input csr_data_type deadzone, input csr_data_type windup,
                                input csr_data_type upper, input csr_data_type lower);
      wait_idle();
      csr_write(CSR_SETPOINT, setpoint);
      csr_write(CSR_KP, kp);
      csr_write(CSR_KI_DT, ki);
      csr_write(CSR_KD_DT, kd);
      csr_write(CSR_DEADZONE, deadzone);
      csr_write(CSR_WINDUP, windup);
      csr_write(CSR_UPPER, upper);
      csr_write(CSR_LOWER, lower);
   endtask

   function automatic position_type pick_position();
      int pos;
      if ($urandom_range(0, 7) == 0) begin
         return position_type'($urandom_range(0, 4095));
      end
      pos = int'(cfg_setpoint) + int'($urandom_range(0, 120)) - 60;
      if (pos < 0) begin
         pos = 0;
      end
      return position_type'(pos);
   endfunction

   // Response side: random stalls, plus a forced hold-off when a test asks for one.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      pulse_result_type exp_result;
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (pulse_queue.size() == 0) begin
            $error("Response transaction arrived with no sample outstanding");
            error_count++;
         end else begin
            exp_result = pulse_queue.pop_front();
            if (exp_result.sat) begin
               saturated_count++;
            end
            if (rsp_pulse_adjust_us !== exp_result.pulse) begin
               $error("pulse_adjust_us mismatch: expected %0d, actual %0d",
                      exp_result.pulse, rsp_pulse_adjust_us);
               error_count++;
            end
            if (rsp_saturated !== exp_result.sat) begin
               $error("saturated mismatch: expected %0b, actual %0b",
                      exp_result.sat, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_values();
      send_position(12'd0);
      send_position(12'd4095);
      send_position(12'd100);
      send_position(12'd99);
      send_position(12'd101);
      send_position(12'd98);
      send_position(12'd102);
      send_position(12'd60);
   endtask

   task automatic test_setpoint_clamp();
      wait_idle();
      csr_write(CSR_SETPOINT, 16'h0000);
      send_position(12'd30);
      send_position(12'd0);
      wait_idle();
      csr_write(CSR_SETPOINT, 16'hFFFF);
      send_position(12'd130);
      send_position(12'd200);
   endtask

   task automatic test_gain_extremes();
      program_gains(16'd130, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15, 16'hFFFF, 16'd127, 16'd127);
      send_position(12'd0);
      send_position(12'd4095);
      send_position(12'd0);
      send_position(12'd125);
      send_position(12'd144);
   endtask

   task automatic test_zero_limits();
      program_gains(16'd80, 16'd3840, 16'd64, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd0);
      send_position(12'd0);
      send_position(12'd4095);
      send_position(12'd80);
   endtask

   task automatic test_windup_lowered();
      program_gains(16'd130, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd127, 16'd127);
      send_position(12'd0);
      send_position(12'd0);
      wait_idle();
      csr_write(CSR_WINDUP, 16'd100);
      send_position(12'd130);
      wait_idle();
      csr_write(CSR_WINDUP, 16'd0);
      send_position(12'd0);
   endtask

   task automatic test_random_settings(input int phases, input int items_per_phase);
      bit wide;
      for (int ph = 0; ph < phases; ph++) begin
         wide = ($urandom_range(0, 3) == 0);
         req_gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
         rsp_stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(10, 50);
         program_gains(csr_data_type'($urandom_range(0, 255)),
                       csr_data_type'(wide ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 1024)),
                       csr_data_type'(wide ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 256)),
                       csr_data_type'(wide ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 2048)),
                       csr_data_type'($urandom_range(0, 15)),
                       csr_data_type'(wide ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 8192)),
                       csr_data_type'($urandom_range(0, 127)),
                       csr_data_type'($urandom_range(0, 127)));
         for (int i = 0; i < items_per_phase; i++) begin
            send_position(pick_position());
         end
      end
   endtask

   task automatic test_output_backpressure();
      program_gains(16'd100, 16'd512, 16'd32, 16'd256, 16'd2, 16'd38400, 16'd40, 16'd30);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      @(negedge clock);
      rsp_hold_cycles = 200;
      for (int i = 0; i < 30; i++) begin
         send_position(pick_position());
      end
   endtask

   task automatic test_sender_pause();
      req_gap_pct   = 20;
      rsp_stall_pct = 30;
      for (int burst = 0; burst < 3; burst++) begin
         for (int i = 0; i < 10; i++) begin
            send_position(pick_position());
         end
         wait_idle();
      end
   endtask

   initial begin
      reset_controller_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_setpoint_clamp();
      test_gain_extremes();
      test_zero_limits();
      test_windup_lowered();
      test_random_settings(6, 65);
      test_output_backpressure();
      test_sender_pause();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Checked %0d responses for %0d position samples (%0d saturated).",
               response_count, sample_count, saturated_count);
      $display("Gains and limits were changed by %0d register writes, extremes included.",
               write_count);
      if (error_count == 0 && pulse_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ppc_pkg.sv
hdl/pid_position_controller_core.sv
tb/sv/tb_pid_position_controller_core.sv
